/* rtl/core/pba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, constants and width helpers for the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int DEF_REGION_PAGES = 4096;
    localparam int DEF_REGION_COUNT = 3;

    localparam int ADDR_W        = 52;
    localparam int PAGES_W       = 13;
    localparam int RUN_W         = 13;
    localparam int CFG_INDEX_W   = 3;
    localparam int PAGE_SHIFT    = 12;
    localparam int HINT_PAGE_W   = 12;
    localparam int HINT_REGION_W = 2;

    // request kinds
    localparam logic ACT_SINGLE = 1'b0;
    localparam logic ACT_RUN    = 1'b1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_REGION0_BASE  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION0_PAGES = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION1_BASE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION1_PAGES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION2_BASE  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REGION2_PAGES = 3'd5;

    typedef struct packed {
        logic               action;
        logic [RUN_W-1:0]   run_length;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  phys_address;
        logic               ok;
    } rsp_t;

    typedef struct packed {
        logic               single_found;
        logic [2:0]         single_bit;
        logic               run_found;
        logic [2:0]         run_bit;
        logic [RUN_W-1:0]   run_count;
    } byte_eval_t;

    function automatic int bytes_per_region(input int rp);
        return (rp + 7) >> 3;
    endfunction

    function automatic int byte_w(input int rp);
        return (bytes_per_region(rp) > 1) ? $clog2(bytes_per_region(rp)) : 1;
    endfunction

    // bit position of a page inside its region
    function automatic int pos_w(input int rp);
        return byte_w(rp) + 3;
    endfunction

    // page count, 0 .. rp
    function automatic int page_w(input int rp);
        return $clog2(rp + 1);
    endfunction

    function automatic int region_w(input int rc);
        return (rc > 1) ? $clog2(rc) : 1;
    endfunction

    function automatic int mem_depth(input int rp, input int rc);
        return rc * bytes_per_region(rp);
    endfunction

    function automatic int mem_aw(input int rp, input int rc);
        return (mem_depth(rp, rc) > 1) ? $clog2(mem_depth(rp, rc)) : 1;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/page_bitmap_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Physical page allocator over a byte-wide used-page bitmap: first-fit runs, singles from the hint.
// ----------------------------------------------------------------------------
// Flow: SINGLE or RUN scans bytes in order, MARK sets a found run's bytes,
//   DONE gives the result. The bitmap read port, one byte a cycle, sets the pace.
// Throughput: one request at a time, busy high until the result beat.
// Reset: clearing pass over all REGION_COUNT * REGION_PAGES / 8 bitmap
//   bytes (1536 by default), busy high meanwhile; results cannot stall.
module page_bitmap_allocator
    import pba_pkg::*;
#(
    parameter int REGION_PAGES = DEF_REGION_PAGES,
    parameter int REGION_COUNT = DEF_REGION_COUNT
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  req_t                   req,
    output logic                   done,
    output rsp_t                   rsp,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data
);

    localparam int BPR   = bytes_per_region(REGION_PAGES);
    localparam int BW    = byte_w(REGION_PAGES);
    localparam int XW    = pos_w(REGION_PAGES);
    localparam int EW    = XW + 1;
    localparam int PW    = page_w(REGION_PAGES);
    localparam int RW    = region_w(REGION_COUNT);
    localparam int AW    = mem_aw(REGION_PAGES, REGION_COUNT);
    localparam int DEPTH = mem_depth(REGION_PAGES, REGION_COUNT);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SINGLE = 3'd2;
    localparam logic [2:0] S_RUN    = 3'd3;
    localparam logic [2:0] S_MARK   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [AW-1:0]            clr_reg, clr_next;
    logic [RW-1:0]            region_reg, region_next;
    logic [BW-1:0]            byte_reg, byte_next;
    logic                     first_reg, first_next;
    logic [RUN_W-1:0]         cnt_reg, cnt_next;
    logic [RUN_W-1:0]         want_reg, want_next;
    logic [XW-1:0]            start_reg, start_next;
    logic [XW-1:0]            end_reg, end_next;
    logic                     ok_reg, ok_next;
    logic [HINT_REGION_W-1:0] hint_region_reg, hint_region_next;
    logic [HINT_PAGE_W-1:0]   hint_page_reg, hint_page_next;
    logic                     done_reg, done_next;
    rsp_t                     rsp_reg, rsp_next;

    logic                     cfg_hit;
    logic [ADDR_W-1:0]        base [REGION_COUNT];
    logic [PW-1:0]            npages [REGION_COUNT];

    logic [AW-1:0]            rd_addr;
    logic [7:0]               rd_data;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [7:0]               wr_data;

    byte_eval_t               eval;
    logic [7:0]               mark_mask;
    logic [2:0]               skip;
    logic [PW-1:0]            npages_cur;
    logic                     stay;
    logic                     last_region;
    logic [XW-1:0]            single_page;
    logic [XW-1:0]            run_page;
    logic [ADDR_W-1:0]        addr_sum;

    function automatic logic [AW-1:0] byte_addr(input logic [RW-1:0] r,
                                                input logic [BW-1:0] b);
        return AW'(r) * AW'(BPR) + AW'(b);
    endfunction

    pba_regs #(
        .REGION_PAGES (REGION_PAGES),
        .REGION_COUNT (REGION_COUNT)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_hit   (cfg_hit),
        .base      (base),
        .npages    (npages)
    );

    pba_bitmap #(
        .REGION_PAGES (REGION_PAGES),
        .REGION_COUNT (REGION_COUNT)
    ) u_bitmap (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    pba_byte_unit #(
        .REGION_PAGES (REGION_PAGES)
    ) u_byte (
        .data      (rd_data),
        .byte_idx  (byte_reg),
        .npages    (npages_cur),
        .skip      (skip),
        .cnt_in    (cnt_reg),
        .want      (want_reg),
        .mark_lo   (start_reg),
        .mark_hi   (end_reg),
        .eval      (eval),
        .mark_mask (mark_mask)
    );

    assign npages_cur  = npages[region_reg];
    assign skip        = (first_reg && (state_reg == S_SINGLE)) ? hint_page_reg[2:0] : 3'd0;
    assign stay        = EW'({({1'b0, byte_reg} + 1'b1), 3'b000}) < EW'(npages_cur);
    assign last_region = (region_reg == RW'(REGION_COUNT - 1));
    assign single_page = {byte_reg, eval.single_bit};
    assign run_page    = {byte_reg, eval.run_bit};
    assign addr_sum    = base[region_reg] + (ADDR_W'(start_reg) << PAGE_SHIFT);

    // data for the next cycle always follows the next pointer
    assign rd_addr = byte_addr(region_next, byte_next);

    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        region_next      = region_reg;
        byte_next        = byte_reg;
        first_next       = first_reg;
        cnt_next         = cnt_reg;
        want_next        = want_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        ok_next          = ok_reg;
        hint_region_next = hint_region_reg;
        hint_page_next   = hint_page_reg;
        done_next        = 1'b0;
        rsp_next         = rsp_reg;
        wr_en            = 1'b0;
        wr_addr          = byte_addr(region_reg, byte_reg);
        wr_data          = rd_data;

        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = 8'h00;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    want_next = req.run_length;
                    cnt_next  = '0;
                    ok_next   = 1'b0;
                    if (req.action == ACT_SINGLE)
                    begin
                        region_next = RW'(hint_region_reg);
                        byte_next   = BW'(hint_page_reg >> 3);
                        first_next  = 1'b1;
                        state_next  = S_SINGLE;
                    end
                    else if (req.run_length == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        region_next = '0;
                        byte_next   = '0;
                        state_next  = S_RUN;
                    end
                end
            end
            S_SINGLE:
            begin
                first_next = 1'b0;
                if (eval.single_found)
                begin
                    wr_en            = 1'b1;
                    wr_data          = rd_data | (8'h01 << eval.single_bit);
                    hint_region_next = HINT_REGION_W'(region_reg);
                    hint_page_next   = HINT_PAGE_W'(single_page);
                    start_next       = single_page;
                    ok_next          = 1'b1;
                    state_next       = S_DONE;
                end
                else if (stay)
                begin
                    byte_next = byte_reg + 1'b1;
                end
                else if (last_region)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    region_next = region_reg + 1'b1;
                    byte_next   = '0;
                end
            end
            S_RUN:
            begin
                if (eval.run_found)
                begin
                    start_next = XW'(EW'(run_page) + EW'(1) - EW'(want_reg));
                    end_next   = run_page;
                    byte_next  = start_next[XW-1:3];
                    state_next = S_MARK;
                end
                else if (stay)
                begin
                    cnt_next  = eval.run_count;
                    byte_next = byte_reg + 1'b1;
                end
                else if (last_region)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next    = '0;
                    region_next = region_reg + 1'b1;
                    byte_next   = '0;
                end
            end
            S_MARK:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data | mark_mask;
                if (byte_reg == end_reg[XW-1:3])
                begin
                    ok_next    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    byte_next = byte_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                done_next             = 1'b1;
                rsp_next.ok           = ok_reg;
                rsp_next.phys_address = ok_reg ? addr_sum : '0;
                state_next            = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // any write to a region register returns the hint to the first page
        if (cfg_hit)
        begin
            hint_region_next = '0;
            hint_page_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_reg         <= '0;
            region_reg      <= '0;
            byte_reg        <= '0;
            first_reg       <= 1'b0;
            cnt_reg         <= '0;
            want_reg        <= '0;
            ok_reg          <= 1'b0;
            hint_region_reg <= '0;
            hint_page_reg   <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            region_reg      <= region_next;
            byte_reg        <= byte_next;
            first_reg       <= first_next;
            cnt_reg         <= cnt_next;
            want_reg        <= want_next;
            ok_reg          <= ok_next;
            hint_region_reg <= hint_region_next;
            hint_page_reg   <= hint_page_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        rsp_reg   <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule
`default_nettype wire

/* rtl/core/pba_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_regs
// Region configuration registers with usable page count clamping.
// ----------------------------------------------------------------------------
module pba_regs
    import pba_pkg::*;
#(
    parameter int REGION_PAGES = DEF_REGION_PAGES,
    parameter int REGION_COUNT = DEF_REGION_COUNT
)(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [CFG_INDEX_W-1:0]           cfg_index,
    input  logic [ADDR_W-1:0]                cfg_data,
    output logic                             cfg_hit,
    output logic [ADDR_W-1:0]                base [REGION_COUNT],
    output logic [page_w(REGION_PAGES)-1:0]  npages [REGION_COUNT]
);

    localparam int PW   = page_w(REGION_PAGES);
    localparam int CMPW = (PW > PAGES_W) ? PW : PAGES_W;

    logic       hit;
    logic [1:0] sel;
    logic       is_pages;

    always_comb
    begin
        hit      = 1'b0;
        sel      = 2'd0;
        is_pages = 1'b0;
        case (cfg_index)
            REG_REGION0_BASE:
            begin
                hit = 1'b1;
                sel = 2'd0;
            end
            REG_REGION0_PAGES:
            begin
                hit      = 1'b1;
                sel      = 2'd0;
                is_pages = 1'b1;
            end
            REG_REGION1_BASE:
            begin
                hit = 1'b1;
                sel = 2'd1;
            end
            REG_REGION1_PAGES:
            begin
                hit      = 1'b1;
                sel      = 2'd1;
                is_pages = 1'b1;
            end
            REG_REGION2_BASE:
            begin
                hit = 1'b1;
                sel = 2'd2;
            end
            REG_REGION2_PAGES:
            begin
                hit      = 1'b1;
                sel      = 2'd2;
                is_pages = 1'b1;
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    assign cfg_hit = cfg_we && hit;

    for (genvar r = 0; r < REGION_COUNT; r++)
    begin : g_region
        logic [ADDR_W-1:0]  base_reg;
        logic [PAGES_W-1:0] pages_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                base_reg  <= '0;
                pages_reg <= '0;
            end
            else if (cfg_hit && (sel == 2'(r)))
            begin
                if (is_pages)
                begin
                    pages_reg <= cfg_data[PAGES_W-1:0];
                end
                else
                begin
                    base_reg <= cfg_data;
                end
            end
        end

        // oversized counts clamp to the region size
        always_comb
        begin
            if (CMPW'(pages_reg) > CMPW'(REGION_PAGES))
            begin
                npages[r] = PW'(REGION_PAGES);
            end
            else
            begin
                npages[r] = PW'(pages_reg);
            end
        end

        assign base[r] = base_reg;
    end

endmodule
`default_nettype wire

/* rtl/core/pba_bitmap.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_bitmap
// Used-page bitmap store, one byte per word, one write and one read port.
// ----------------------------------------------------------------------------
module pba_bitmap
    import pba_pkg::*;
#(
    parameter int REGION_PAGES = DEF_REGION_PAGES,
    parameter int REGION_COUNT = DEF_REGION_COUNT
)(
    input  logic                                         clk,
    input  logic [mem_aw(REGION_PAGES, REGION_COUNT)-1:0] rd_addr,
    output logic [7:0]                                   rd_data,
    input  logic                                         wr_en,
    input  logic [mem_aw(REGION_PAGES, REGION_COUNT)-1:0] wr_addr,
    input  logic [7:0]                                   wr_data
);

    localparam int DEPTH = mem_depth(REGION_PAGES, REGION_COUNT);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/pba_byte_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_byte_unit
// Shared per-byte evaluator: first free page, free run count and mark mask.
// ----------------------------------------------------------------------------
module pba_byte_unit
    import pba_pkg::*;
#(
    parameter int REGION_PAGES = DEF_REGION_PAGES
)(
    input  logic [7:0]                       data,
    input  logic [byte_w(REGION_PAGES)-1:0]  byte_idx,
    input  logic [page_w(REGION_PAGES)-1:0]  npages,
    input  logic [2:0]                       skip,
    input  logic [RUN_W-1:0]                 cnt_in,
    input  logic [RUN_W-1:0]                 want,
    input  logic [pos_w(REGION_PAGES)-1:0]   mark_lo,
    input  logic [pos_w(REGION_PAGES)-1:0]   mark_hi,
    output byte_eval_t                       eval,
    output logic [7:0]                       mark_mask
);

    localparam int XW = pos_w(REGION_PAGES);
    localparam int EW = XW + 1;

    logic [EW-1:0]    page_e [8];
    logic [7:0]       in_range;
    logic [7:0]       candidate;
    logic [7:0]       free_bit;
    logic [7:0]       all_free;
    logic [7:0]       lo_mask;
    logic [2:0]       last_used;
    logic [RUN_W-1:0] run_len [8];
    logic             run_hit;
    logic [2:0]       run_pos;
    logic             single_hit;
    logic [2:0]       single_pos;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            page_e[i]    = EW'({byte_idx, 3'(i)});
            in_range[i]  = page_e[i] < EW'(npages);
            candidate[i] = in_range[i] && !data[i] && (3'(i) >= skip);
            mark_mask[i] = (page_e[i] >= EW'(mark_lo)) && (page_e[i] <= EW'(mark_hi));
            free_bit[i]  = in_range[i] && !data[i];
        end

        single_hit = 1'b0;
        single_pos = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (candidate[i])
            begin
                single_hit = 1'b1;
                single_pos = 3'(i);
            end
        end

        // free run ending at each bit, carried in from earlier bytes while every bit up to it is free
        for (int i = 0; i < 8; i++)
        begin
            lo_mask     = 8'hFF >> (7 - i);
            all_free[i] = ((free_bit & lo_mask) == lo_mask);
            last_used   = 3'd0;
            for (int j = 0; j < 8; j++)
            begin
                if ((j <= i) && !free_bit[j])
                begin
                    last_used = 3'(j);
                end
            end
            if (all_free[i])
            begin
                run_len[i] = cnt_in + RUN_W'(i + 1);
            end
            else
            begin
                run_len[i] = RUN_W'(3'(i) - last_used);
            end
        end

        run_hit = 1'b0;
        run_pos = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (free_bit[i] && (run_len[i] >= want))
            begin
                run_hit = 1'b1;
                run_pos = 3'(i);
            end
        end

        eval.single_found = single_hit;
        eval.single_bit   = single_pos;
        eval.run_found    = run_hit;
        eval.run_bit      = run_pos;
        eval.run_count    = free_bit[7] ? run_len[7] : '0;
    end

endmodule
`default_nettype wire

/* rtl/core/pba_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks on the allocator request and result beats.
// ----------------------------------------------------------------------------
module pba_checker
    import pba_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic done,
    input  rsp_t rsp
);

    // an accepted request keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted request");

    // the result beat closes the request
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result beat without a finishing request");

    // a failed request carries a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.ok) |-> (rsp.phys_address == '0))
        else $error("failed request with non-zero address");

    // one beat per request, never back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat repeated");

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);
`default_nettype wire

/* dv/page_bitmap_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator_tb
// Self-checking bench for the page allocator. A model of the three region
// bitmaps and the single-page hint predicts every grant: request beats are
// sent with random gaps or none, and each result beat is checked against the oldest
// prediction. Region registers change only between phases while the block is
// idle. Phases cover edge cases, then random traffic, then full-size regions.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_tb;
    import pba_pkg::*;

    localparam int  ITEMS_PER_PHASE = 100;
    localparam int  RANDOM_PHASES   = 9;
    localparam int  SETTLE_CYCLES   = 2200;
    localparam longint CYCLE_LIMIT  = 8000000;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE7 = 3'd7;

    localparam logic [ADDR_W-1:0] TOP_FRAME = 52'hF_FFFF_FFFF_F000;
    localparam logic [ADDR_W-1:0] ALL_ONES  = 52'hF_FFFF_FFFF_FFFF;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    req_t                   req;
    logic                   done;
    rsp_t                   rsp;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [ADDR_W-1:0]      cfg_data;

    // model of the allocator
    logic [ADDR_W-1:0]  region_base_q  [DEF_REGION_COUNT];
    logic [PAGES_W-1:0] region_pages_q [DEF_REGION_COUNT];
    bit                 page_taken [DEF_REGION_COUNT][DEF_REGION_PAGES];
    int unsigned        hint_region;
    int unsigned        hint_page;

    rsp_t   pending_grants[$];
    int     error_count;
    int     items_sent;
    int     singles_granted;
    int     runs_granted;
    int     refusals;
    int     reg_writes;
    longint cycle_count;
    bit     no_idle_stretch;

    page_bitmap_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int usable_pages(int r);
        if (region_pages_q[r] > DEF_REGION_PAGES)
            return DEF_REGION_PAGES;
        return int'(region_pages_q[r]);
    endfunction

    function automatic logic [ADDR_W-1:0] frame_address(int r, int p);
        logic [ADDR_W-1:0] offset;
        offset = ADDR_W'(p);
        return region_base_q[r] + (offset << PAGE_SHIFT);
    endfunction

    function automatic void apply_reg_write(logic [CFG_INDEX_W-1:0] idx,
                                            logic [ADDR_W-1:0] data);
        case (idx)
            REG_REGION0_BASE:  region_base_q[0]  = data;
            REG_REGION0_PAGES: region_pages_q[0] = data[PAGES_W-1:0];
            REG_REGION1_BASE:  region_base_q[1]  = data;
            REG_REGION1_PAGES: region_pages_q[1] = data[PAGES_W-1:0];
            REG_REGION2_BASE:  region_base_q[2]  = data;
            REG_REGION2_PAGES: region_pages_q[2] = data[PAGES_W-1:0];
            default:           return;
        endcase
        hint_region = 0;
        hint_page   = 0;
    endfunction

    function automatic rsp_t allocate_frames(req_t item);
        rsp_t grant;
        int   n;
        int   want;
        int   streak;
        int   first;
        grant = '0;
        if (item.action == ACT_SINGLE)
        begin
            for (int r = int'(hint_region); r < DEF_REGION_COUNT; r++)
            begin
                n = usable_pages(r);
                for (int p = (r == int'(hint_region)) ? int'(hint_page) : 0; p < n; p++)
                begin
                    if (!page_taken[r][p])
                    begin
                        page_taken[r][p]   = 1'b1;
                        hint_region        = r;
                        hint_page          = p;
                        grant.phys_address = frame_address(r, p);
                        grant.ok           = 1'b1;
                        singles_granted++;
                        return grant;
                    end
                end
            end
            refusals++;
            return grant;
        end
        want = int'(item.run_length);
        if (want == 0)
        begin
            refusals++;
            return grant;
        end
        for (int r = 0; r < DEF_REGION_COUNT; r++)
        begin
            n      = usable_pages(r);
            streak = 0;
            for (int p = 0; p < n; p++)
            begin
                if (page_taken[r][p])
                    streak = 0;
                else
                begin
                    streak++;
                    if (streak >= want)
                    begin
                        first = p + 1 - want;
                        for (int q = first; q <= p; q++)
                            page_taken[r][q] = 1'b1;
                        grant.phys_address = frame_address(r, first);
                        grant.ok           = 1'b1;
                        runs_granted++;
                        return grant;
                    end
                end
            end
        end
        refusals++;
        return grant;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        error_count++;
        $display("MISMATCH at %0t: %s, expected %h, got %h", $time, what, want, got);
    endtask

    // result checker
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_grants.size() == 0)
                report_mismatch("result beat with nothing outstanding", '0, 64'(rsp));
            else
            begin
                want = pending_grants.pop_front();
                if (rsp.ok !== want.ok)
                    report_mismatch("ok", 64'(want.ok), 64'(rsp.ok));
                if (rsp.phys_address !== want.phys_address)
                    report_mismatch("phys_address", 64'(want.phys_address),
                                    64'(rsp.phys_address));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic act, input logic [RUN_W-1:0] len);
        req_t item;
        item.action     = act;
        item.run_length = len;
        if (!no_idle_stretch)
            repeat ($urandom_range(0, 17)) @(posedge clk);
        @(posedge clk);
        start <= 1'b1;
        req   <= item;
        do
            @(posedge clk);
        while (busy);
        start <= 1'b0;
        pending_grants.push_back(allocate_frames(item));
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [ADDR_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        apply_reg_write(idx, data);
        reg_writes++;
    endtask

    task automatic wait_drained();
        while (pending_grants.size() != 0)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        while (pending_grants.size() != 0 || busy)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [ADDR_W-1:0] random_base();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return {raw[51:12], 12'h000};
            1:       return raw[51:0];
            2:       return {36'hF_FFFF_FFFF, raw[15:12], 12'h000};
            default: return {36'hF_FFFF_FFFF, raw[15:0]};
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] pages_word(int pages);
        logic [63:0]        raw;
        logic [PAGES_W-1:0] count;
        raw   = {$urandom, $urandom};
        count = PAGES_W'(pages);
        if ($urandom_range(0, 1))
            return {raw[ADDR_W-1:PAGES_W], count};
        return {{(ADDR_W-PAGES_W){1'b0}}, count};
    endfunction

    task automatic test_after_reset();
        wait_idle();
        send_request(ACT_SINGLE, '0);
        send_request(ACT_RUN, 13'd1);
    endtask

    task automatic test_directed_corners();
        wait_idle();
        write_reg(REG_REGION0_BASE,  52'h0_0000_0000_1000);
        write_reg(REG_REGION0_PAGES, pages_word(8));
        write_reg(REG_REGION1_BASE,  TOP_FRAME);
        write_reg(REG_REGION1_PAGES, pages_word(6));
        write_reg(REG_REGION2_BASE,  52'h0_0000_0000_0ABC);
        write_reg(REG_REGION2_PAGES, '0);
        send_request(ACT_SINGLE, 13'h1FFF);
        send_request(ACT_SINGLE, 13'd0);
        send_request(ACT_RUN,    13'd0);
        send_request(ACT_RUN,    13'd3);
        send_request(ACT_RUN,    13'h1FFF);
        send_request(ACT_RUN,    13'd4);
        send_request(ACT_SINGLE, 13'h0AAA);
        send_request(ACT_SINGLE, 13'h1555);
        send_request(ACT_SINGLE, 13'd1);
        // region 1 tail wraps past the top of the address space
        send_request(ACT_SINGLE, 13'd2);
        send_request(ACT_SINGLE, 13'd4096);
        send_request(ACT_SINGLE, 13'd7);
        send_request(ACT_RUN,    13'd1);
    endtask

    task automatic test_spare_index_and_regrow();
        wait_idle();
        write_reg(REG_SPARE6, ALL_ONES);
        write_reg(REG_SPARE7, 52'h0_0000_0000_0005);
        send_request(ACT_SINGLE, 13'd0);
        wait_idle();
        write_reg(REG_REGION2_PAGES, pages_word(5));
        send_request(ACT_SINGLE, 13'd0);
        send_request(ACT_RUN,    13'd5);
        send_request(ACT_RUN,    13'd4);
        send_request(ACT_SINGLE, 13'd0);
        wait_idle();
        // oversized count acts as a full region
        write_reg(REG_REGION0_PAGES, pages_word(8191));
        send_request(ACT_SINGLE, 13'd0);
        send_request(ACT_RUN,    13'd4096);
    endtask

    task automatic random_item();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            send_request(ACT_SINGLE, RUN_W'($urandom));
        else if (sel < 85)
            send_request(ACT_RUN, RUN_W'($urandom_range(1, 8)));
        else if (sel < 95)
            send_request(ACT_RUN, RUN_W'($urandom_range(9, 64)));
        else if (sel < 97)
            send_request(ACT_RUN, '0);
        else if (sel < 99)
            send_request(ACT_RUN, RUN_W'($urandom_range(65, 8191)));
        else
            send_request(ACT_RUN, $urandom_range(0, 1) ? 13'd4096 : 13'h1FFF);
    endtask

    task automatic test_random_phases();
        int hi;
        int drain_at;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            hi = 150 * (ph + 1);
            write_reg(REG_REGION0_BASE,  random_base());
            write_reg(REG_REGION0_PAGES, pages_word($urandom_range(8 * (ph + 1), hi)));
            write_reg(REG_REGION1_PAGES, pages_word($urandom_range(8 * (ph + 1), hi)));
            write_reg(REG_REGION1_BASE,  random_base());
            write_reg(REG_REGION2_PAGES, pages_word(($urandom_range(0, 4) == 0) ? 0 :
                                                   $urandom_range(8, hi)));
            write_reg(REG_REGION2_BASE,  random_base());
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7,
                          52'({$urandom, $urandom}));
            drain_at = $urandom_range(10, ITEMS_PER_PHASE - 10);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if ($urandom_range(0, 29) == 0)
                    no_idle_stretch = !no_idle_stretch;
                if (i == drain_at)
                    wait_drained();
                random_item();
            end
            no_idle_stretch = 1'b0;
        end
    endtask

    task automatic test_largest_regions();
        wait_idle();
        write_reg(REG_REGION0_BASE,  '0);
        write_reg(REG_REGION0_PAGES, pages_word(4096));
        write_reg(REG_REGION1_BASE,  ALL_ONES);
        write_reg(REG_REGION1_PAGES, pages_word(4096));
        write_reg(REG_REGION2_BASE,  random_base());
        write_reg(REG_REGION2_PAGES, ALL_ONES);
        send_request(ACT_SINGLE, 13'd0);
        send_request(ACT_RUN,    13'd4096);
        send_request(ACT_RUN,    13'd2048);
        send_request(ACT_RUN,    13'd1500);
        send_request(ACT_SINGLE, 13'h1FFF);
        send_request(ACT_RUN,    13'h1FFF);
        send_request(ACT_RUN,    13'd2047);
        send_request(ACT_SINGLE, 13'd0);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        req       <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        error_count     = 0;
        items_sent      = 0;
        singles_granted = 0;
        runs_granted    = 0;
        refusals        = 0;
        reg_writes      = 0;
        cycle_count     = 0;
        no_idle_stretch = 1'b0;
        hint_region     = 0;
        hint_page       = 0;
        for (int r = 0; r < DEF_REGION_COUNT; r++)
        begin
            region_base_q[r]  = '0;
            region_pages_q[r] = '0;
            for (int p = 0; p < DEF_REGION_PAGES; p++)
                page_taken[r][p] = 1'b0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_directed_corners();
        test_spare_index_and_regrow();
        test_random_phases();
        test_largest_regions();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("%0d requests: %0d single pages and %0d runs granted, %0d refused",
                 items_sent, singles_granted, runs_granted, refusals);
        $display("%0d register writes, %0d mismatches", reg_writes, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
